// ===== rtl/core/fsmon_pkg.sv =====
// Fluidics sensor monitor package: microcode ROM, control types, register
// indexes and reset constants. It depends on nothing else.
package fsmon_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SET_POINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_OFFSET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ALMOST_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LIMIT  = 3'd7;

    localparam logic [14:0]        SET_POINT_RST    = 15'd768;
    localparam logic [14:0]        PRESS_TOL_RST    = 15'd64;
    localparam logic signed [15:0] REF_TEMP_RST     = 16'sd5120;
    localparam logic signed [15:0] TEMP_FACTOR_RST  = 16'sd4588;
    localparam logic [11:0]        DAC_GAIN_RST     = 12'd273;
    localparam logic [11:0]        DAC_OFFSET_RST   = 12'd1501;
    localparam logic [7:0]         ALMOST_LIMIT_RST = 8'd60;
    localparam logic [7:0]         EMPTY_LIMIT_RST  = 8'd120;
    localparam logic signed [16:0] CORR_POINT_RST   = 17'sd768;

    localparam logic [7:0] LIMIT_MIN = 8'd1;
    localparam logic [7:0] LIMIT_MAX = 8'd250;

    typedef enum logic [1:0] {
        STEP_WAIT,
        STEP_CORR,
        STEP_MULB,
        STEP_EMIT
    } t_step;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,
        COND_OUT
    } t_cond;

    typedef enum logic {
        MUL_TEMP,
        MUL_DAC
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_prod;
        logic     ld_cp;
        logic     ld_code;
        t_cond    cond;
        t_step    target;
    } t_uop;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_prod;
        logic     ld_cp;
    } t_dp_ctl;

    typedef struct packed {
        logic degas;
        logic plenum;
        logic a_alarm;
        logic e_alarm;
        logic err;
        logic f_alarm;
        logic h_alarm;
        logic stop;
        logic solenoid;
    } t_flags;

    // Microprogram: the jump to target is taken when cond holds, else the step repeats.
    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '{mul_sel: MUL_TEMP, ld_prod: 1'b0, ld_cp: 1'b0, ld_code: 1'b0,
              cond: COND_ALWAYS, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT: begin
                u.mul_sel = MUL_TEMP;
                u.ld_prod = 1'b1;
                u.cond    = COND_IN;
                u.target  = STEP_CORR;
            end
            STEP_CORR: begin
                u.ld_cp  = 1'b1;
                u.target = STEP_MULB;
            end
            STEP_MULB: begin
                u.mul_sel = MUL_DAC;
                u.ld_prod = 1'b1;
                u.target  = STEP_EMIT;
            end
            STEP_EMIT: begin
                u.ld_code = 1'b1;
                u.cond    = COND_OUT;
                u.target  = STEP_WAIT;
            end
        endcase
        return u;
    endfunction

    function automatic logic [7:0] clamp_limit(input logic [7:0] v);
        logic [7:0] r;
        if (v < LIMIT_MIN) begin
            r = LIMIT_MIN;
        end else if (v > LIMIT_MAX) begin
            r = LIMIT_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/fsmon_arith.sv =====
// Setpoint datapath: one shared signed multiplier, product and corrected
// setpoint registers, rounding and DAC code saturation. Uses fsmon_pkg.
module fsmon_arith (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fsmon_pkg::t_dp_ctl    i_ctl,
    input  logic signed [15:0]    i_temperature,
    input  logic signed [15:0]    i_ref_temperature,
    input  logic signed [15:0]    i_temp_factor,
    input  logic [14:0]           i_set_point,
    input  logic [11:0]           i_dac_gain,
    input  logic [11:0]           i_dac_offset,
    output logic signed [16:0]    o_corr_point,
    output logic [11:0]           o_code
);
    import fsmon_pkg::*;

    logic signed [17:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [35:0] w_mul_p;
    logic signed [16:0] w_dtemp;
    logic signed [33:0] w_round;
    logic signed [17:0] w_corr;
    logic signed [18:0] w_cp_raw;
    logic signed [16:0] w_cp_sat;
    logic signed [21:0] w_quot;
    logic signed [22:0] w_sum;
    logic signed [32:0] r_prod;
    logic signed [16:0] r_cp;

    assign w_dtemp = {i_temperature[15], i_temperature}
                   - {i_ref_temperature[15], i_ref_temperature};

    always_comb begin
        unique case (i_ctl.mul_sel)
            MUL_TEMP: begin
                w_mul_a = {{2{i_temp_factor[15]}}, i_temp_factor};
                w_mul_b = {w_dtemp[16], w_dtemp};
            end
            MUL_DAC: begin
                w_mul_a = {r_cp[16], r_cp};
                w_mul_b = {6'b0, i_dac_gain};
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // round half up, then floor by 2^16
    assign w_round  = {r_prod[32], r_prod} + 34'sd32768;
    assign w_corr   = w_round[33:16];
    assign w_cp_raw = $signed({4'b0, i_set_point}) - {w_corr[17], w_corr};

    always_comb begin
        if (w_cp_raw[18:16] == 3'b000 || w_cp_raw[18:16] == 3'b111) begin
            w_cp_sat = w_cp_raw[16:0];
        end else if (w_cp_raw[18]) begin
            w_cp_sat = 17'sh10000;
        end else begin
            w_cp_sat = 17'sh0FFFF;
        end
    end

    assign w_quot = r_prod[29:8];
    assign w_sum  = {w_quot[21], w_quot} + $signed({11'b0, i_dac_offset});

    always_comb begin
        if (w_sum[22]) begin
            o_code = 12'd0;
        end else if (w_sum[21:12] != 10'd0) begin
            o_code = 12'hFFF;
        end else begin
            o_code = w_sum[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_prod) begin
            r_prod <= w_mul_p[32:0];
        end
        if (!i_rst_n) begin
            r_cp <= CORR_POINT_RST;
        end else if (i_ctl.ld_cp) begin
            r_cp <= w_cp_sat;
        end
    end

    assign o_corr_point = r_cp;

endmodule

// ===== rtl/core/fluidics_sensor_monitor.sv =====
// Fluidics sensor monitor top level: microcode sequencer, config registers,
// sensor logic and output register. Uses fsmon_pkg and fsmon_arith.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    sensor bits, pressure, temperature
//   out      source     o_out_valid / i_out_stall  pump, alarm, solenoid, DAC, LED
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A tick runs its steps in order: accept plus first product, corrected setpoint,
// DAC product, output load; the single multiplier is why they run one at a time.
// The output register holds a result under stall while the next tick is accepted;
// the load step waits only if that register is still full.
// Reset is synchronous; config registers and control state reset, flags do not.
module fluidics_sensor_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_degas_sense,
    input  logic                             i_sheath_low,
    input  logic                             i_waste_high,
    input  logic                             i_waste_full,
    input  logic signed [15:0]               i_diff_pressure,
    input  logic signed [15:0]               i_temperature,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_degas_pump,
    output logic                             o_plenum_pump,
    output logic                             o_sheath_low_warn,
    output logic                             o_sheath_dry_alarm,
    output logic                             o_waste_sensor_error,
    output logic                             o_waste_full_alarm,
    output logic                             o_waste_high_alarm,
    output logic                             o_stop_request,
    output logic                             o_relief_solenoid,
    output logic [15:0]                      o_pressure_ref_word,
    output logic                             o_status_led,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsmon_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                      i_cfg_data
);
    import fsmon_pkg::*;

    t_step              r_step;
    t_uop               w_uop;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_go;
    t_dp_ctl            w_dp_ctl;
    logic signed [16:0] w_corr_point;
    logic [11:0]        w_code;

    logic [14:0]        r_set_point;
    logic [14:0]        r_press_tol;
    logic signed [15:0] r_ref_temp;
    logic signed [15:0] r_temp_factor;
    logic [11:0]        r_dac_gain;
    logic [11:0]        r_dac_offset;
    logic [7:0]         r_almost_limit;
    logic [7:0]         r_empty_limit;

    logic [7:0]         r_almost_count, n_almost_count;
    logic [7:0]         r_empty_count, n_empty_count;
    logic               r_high_latched, n_high_latched;
    logic               r_full_latched, n_full_latched;
    logic               r_solenoid;
    logic               r_led;
    t_flags             r_flags, n_flags;

    logic               r_out_valid;
    t_flags             r_out_flags;
    logic [11:0]        r_out_code;
    logic               r_out_led;

    logic [7:0]         w_alim;
    logic [7:0]         w_elim;
    logic [7:0]         w_a_inc;
    logic [7:0]         w_e_inc;
    logic               w_a_hit;
    logic               w_e_hit;
    logic signed [18:0] w_over_diff;
    logic               w_over;
    logic               w_err;

    assign w_uop      = uop_rom(r_step);
    assign o_in_stall = (r_step != STEP_WAIT);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        unique case (w_uop.cond)
            COND_ALWAYS: w_go = 1'b1;
            COND_IN:     w_go = w_in_acc;
            COND_OUT:    w_go = w_out_free;
            default:     w_go = 1'b0;
        endcase
    end

    assign w_dp_ctl = '{mul_sel: w_uop.mul_sel,
                        ld_prod: w_uop.ld_prod && w_go,
                        ld_cp:   w_uop.ld_cp && w_go};

    fsmon_arith u_arith (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_dp_ctl),
        .i_temperature     (i_temperature),
        .i_ref_temperature (r_ref_temp),
        .i_temp_factor     (r_temp_factor),
        .i_set_point       (r_set_point),
        .i_dac_gain        (r_dac_gain),
        .i_dac_offset      (r_dac_offset),
        .o_corr_point      (w_corr_point),
        .o_code            (w_code)
    );

    // sensor logic for the tick being accepted
    assign w_alim  = clamp_limit(r_almost_limit);
    assign w_elim  = clamp_limit(r_empty_limit);
    assign w_a_inc = !i_sheath_low ? 8'd0 :
                     (r_almost_count < w_alim) ? r_almost_count + 8'd1 : r_almost_count;
    assign w_e_inc = !i_sheath_low ? 8'd0 :
                     (r_empty_count < w_elim) ? r_empty_count + 8'd1 : r_empty_count;
    assign w_a_hit = (w_a_inc == w_alim);
    assign w_e_hit = (w_e_inc == w_elim);
    assign w_err   = !i_waste_high && i_waste_full;

    // compares against the setpoint left by the previous tick
    assign w_over_diff = {{3{i_diff_pressure[15]}}, i_diff_pressure}
                       - {{2{w_corr_point[16]}}, w_corr_point};
    assign w_over      = w_over_diff > $signed({4'b0, r_press_tol});

    always_comb begin
        n_almost_count  = w_a_hit ? w_a_inc + 8'd1 : w_a_inc;
        n_empty_count   = w_e_hit ? w_e_inc + 8'd1 : w_e_inc;
        n_flags.degas   = i_degas_sense;
        n_flags.plenum  = i_sheath_low && !w_e_hit;
        n_flags.a_alarm = w_a_hit;
        n_flags.e_alarm = w_e_hit;
        n_flags.err     = w_err;
        n_flags.f_alarm = !w_err && i_waste_full && !r_full_latched;
        n_flags.h_alarm = !w_err && i_waste_high && !r_high_latched;
        n_flags.stop    = w_err || n_flags.f_alarm;
        n_flags.solenoid = w_over && !r_solenoid;
        if (w_err) begin
            n_high_latched = r_high_latched;
            n_full_latched = r_full_latched;
        end else if (i_waste_high) begin
            n_high_latched = 1'b1;
            n_full_latched = r_full_latched || i_waste_full;
        end else begin
            n_high_latched = 1'b0;
            n_full_latched = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= STEP_WAIT;
            r_set_point    <= SET_POINT_RST;
            r_press_tol    <= PRESS_TOL_RST;
            r_ref_temp     <= REF_TEMP_RST;
            r_temp_factor  <= TEMP_FACTOR_RST;
            r_dac_gain     <= DAC_GAIN_RST;
            r_dac_offset   <= DAC_OFFSET_RST;
            r_almost_limit <= ALMOST_LIMIT_RST;
            r_empty_limit  <= EMPTY_LIMIT_RST;
            r_almost_count <= 8'd0;
            r_empty_count  <= 8'd0;
            r_high_latched <= 1'b0;
            r_full_latched <= 1'b0;
            r_solenoid     <= 1'b0;
            r_led          <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_go) begin
                r_step <= w_uop.target;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_SET_POINT:    r_set_point    <= i_cfg_data[14:0];
                    REG_PRESS_TOL:    r_press_tol    <= i_cfg_data[14:0];
                    REG_REF_TEMP:     r_ref_temp     <= i_cfg_data;
                    REG_TEMP_FACTOR:  r_temp_factor  <= i_cfg_data;
                    REG_DAC_GAIN:     r_dac_gain     <= i_cfg_data[11:0];
                    REG_DAC_OFFSET:   r_dac_offset   <= i_cfg_data[11:0];
                    REG_ALMOST_LIMIT: r_almost_limit <= i_cfg_data[7:0];
                    REG_EMPTY_LIMIT:  r_empty_limit  <= i_cfg_data[7:0];
                endcase
            end
            if (w_in_acc) begin
                r_almost_count <= n_almost_count;
                r_empty_count  <= n_empty_count;
                r_high_latched <= n_high_latched;
                r_full_latched <= n_full_latched;
                r_solenoid     <= n_flags.solenoid;
            end
            if (w_uop.ld_code && w_go) begin
                r_out_valid <= 1'b1;
                r_led       <= !r_led;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_flags <= n_flags;
        end
        if (w_uop.ld_code && w_go) begin
            r_out_flags <= r_flags;
            r_out_code  <= w_code;
            r_out_led   <= !r_led;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_degas_pump          = r_out_flags.degas;
    assign o_plenum_pump         = r_out_flags.plenum;
    assign o_sheath_low_warn     = r_out_flags.a_alarm;
    assign o_sheath_dry_alarm    = r_out_flags.e_alarm;
    assign o_waste_sensor_error  = r_out_flags.err;
    assign o_waste_full_alarm    = r_out_flags.f_alarm;
    assign o_waste_high_alarm    = r_out_flags.h_alarm;
    assign o_stop_request        = r_out_flags.stop;
    assign o_relief_solenoid     = r_out_flags.solenoid;
    assign o_pressure_ref_word   = {r_out_code, 4'b0000};
    assign o_status_led          = r_out_led;

endmodule

// ===== rtl/core/fsmon_checker.sv =====
// Port-level assertions for the fluidics sensor monitor and the bind that
// attaches them to fluidics_sensor_monitor. Uses fsmon_pkg.
module fsmon_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_plenum_pump,
    input logic        o_sheath_dry_alarm,
    input logic        o_waste_sensor_error,
    input logic        o_waste_full_alarm,
    input logic        o_stop_request,
    input logic [15:0] o_pressure_ref_word
);
    import fsmon_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pressure_ref_word))
        else $error("result dropped or changed under stall");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before tick finished");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_waste_sensor_error || o_waste_full_alarm) |-> o_stop_request)
        else $error("waste fault without stop request");

    a_empty_pump_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sheath_dry_alarm |-> !o_plenum_pump)
        else $error("plenum pump on in empty alarm transaction");

endmodule

bind fluidics_sensor_monitor fsmon_checker u_fsmon_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_plenum_pump        (o_plenum_pump),
    .o_sheath_dry_alarm   (o_sheath_dry_alarm),
    .o_waste_sensor_error (o_waste_sensor_error),
    .o_waste_full_alarm   (o_waste_full_alarm),
    .o_stop_request       (o_stop_request),
    .o_pressure_ref_word  (o_pressure_ref_word)
);
